// ===== hdl/gsd_pkg.sv =====
// gsd_pkg: shared constants, codes, types and dither functions for the
// gouraud span dither engine. No dependencies.
package gsd_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 16;
  localparam int DELTA_BITS     = COLOR_BITS + 1;
  localparam int NUM_CH         = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W      = $clog2(COLOR_BITS + 1);
  localparam int CFG_IDX_BITS   = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DITHER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DITHER_LOW    = 2'd1;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // channel order of the accumulators
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  localparam logic [7:0] LEVEL_LOW  = 8'd0;
  localparam logic [7:0] LEVEL_MID  = 8'd127;
  localparam logic [7:0] LEVEL_HIGH = 8'd255;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV_START,
    ST_DIV_WAIT
  } back_state_t;

  typedef struct packed {
    logic dither_enable;
    logic dither_low;
  } cfg_t;

  typedef struct packed {
    logic                         start;
    logic signed [DELTA_BITS-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [DELTA_BITS-1:0] quo;
  } div_rsp_t;

  // bayer rank of each cell, row-major over (row & 7, column & 7)
  localparam logic [5:0] BAYER_ORDER [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  // threshold = rank * 255 / 64 + 4
  function automatic logic [7:0] bayer_th(input logic [5:0] idx);
    logic [13:0] prod;
    prod = 14'(BAYER_ORDER[idx]) * 14'd255;
    return 8'(prod >> 6) + 8'd4;
  endfunction

  function automatic logic [7:0] dither_level(input logic [7:0] t1, input logic [7:0] t2,
                                              input logic [7:0] v, input logic low);
    logic hit1;
    logic hit2;
    hit1 = (t1 <= v);
    hit2 = (t2 <= v);
    if (low) begin
      return hit1 ? LEVEL_HIGH : LEVEL_LOW;
    end
    if (hit1) begin
      return hit2 ? LEVEL_HIGH : LEVEL_MID;
    end
    return hit2 ? LEVEL_MID : LEVEL_LOW;
  endfunction

endpackage

// ===== hdl/gouraud_span_dither_engine.sv =====
// gouraud_span_dither_engine: top level, configuration registers and the
// wiring of front end, back end and divider. Depends on gsd_pkg.
//
// Input channel (in_valid / in_stall): opcode 0 loads a span (column range,
// row, start and end colour per channel), opcode 1 steps one pixel. Items are
// held in a two-entry queue, so the input keeps being taken while the back
// end works or the output is stalled.
// Output channel (out_valid / out_stall): one item per step that lands inside
// the span; loads and steps past the end give nothing.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
// dither enable, index 1 two-level dither; other indexes are ignored.
// cfg_ready is always high; write only while the block is idle.
// Timing: a step item is popped from the queue in the cycle that it is emitted,
// and its pixel appears in the output register on the next edge, so steps run
// one per cycle while the output is not stalled. A load runs four 16-bit
// divisions, one per channel, in turn in the shared one-bit-a-cycle divider.
// Reset (rst, synchronous): empties the queue and the output register and
// clears the span state and configuration. A stalled output holds its item
// and steps wait (loads go on); the queue fills and then raises in_stall.
module gouraud_span_dither_engine import gsd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic                    cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    opcode,
  input  logic [COORD_BITS-1:0]   x_start,
  input  logic [COORD_BITS-1:0]   x_end,
  input  logic [COORD_BITS-1:0]   row,
  input  logic [COLOR_BITS-1:0]   red_start,
  input  logic [COLOR_BITS-1:0]   green_start,
  input  logic [COLOR_BITS-1:0]   blue_start,
  input  logic [COLOR_BITS-1:0]   alpha_start,
  input  logic [COLOR_BITS-1:0]   red_end,
  input  logic [COLOR_BITS-1:0]   green_end,
  input  logic [COLOR_BITS-1:0]   blue_end,
  input  logic [COLOR_BITS-1:0]   alpha_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COORD_BITS-1:0]   pixel_x,
  output logic [COORD_BITS-1:0]   pixel_y,
  output logic [7:0]              blue_out,
  output logic [7:0]              green_out,
  output logic [7:0]              red_out,
  output logic [7:0]              alpha_out,
  output logic                    alpha_write,
  output logic                    last_pixel
);

  cfg_t cfg;

  logic [COLOR_BITS-1:0] in_start [NUM_CH];
  logic [COLOR_BITS-1:0] in_end   [NUM_CH];

  logic                  head_valid;
  logic                  head_pop;
  logic                  head_op;
  logic [COORD_BITS-1:0] head_xs;
  logic [COORD_BITS-1:0] head_xe;
  logic [COORD_BITS-1:0] head_row;
  logic [COORD_BITS:0]   head_len;
  logic [COLOR_BITS-1:0] head_start [NUM_CH];
  logic [COLOR_BITS-1:0] head_end   [NUM_CH];

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [COORD_BITS:0]   div_den;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DITHER_ENABLE: cfg.dither_enable <= cfg_data;
        CFG_DITHER_LOW:    cfg.dither_low    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_start[CH_RED]   = red_start;
  assign in_start[CH_GREEN] = green_start;
  assign in_start[CH_BLUE]  = blue_start;
  assign in_start[CH_ALPHA] = alpha_start;
  assign in_end[CH_RED]     = red_end;
  assign in_end[CH_GREEN]   = green_end;
  assign in_end[CH_BLUE]    = blue_end;
  assign in_end[CH_ALPHA]   = alpha_end;

  gsd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .x_start    (x_start),
    .x_end      (x_end),
    .row        (row),
    .in_start   (in_start),
    .in_end     (in_end),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_op    (head_op),
    .head_xs    (head_xs),
    .head_xe    (head_xe),
    .head_row   (head_row),
    .head_len   (head_len),
    .head_start (head_start),
    .head_end   (head_end)
  );

  gsd_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .den (div_den),
    .rsp (div_rsp)
  );

  gsd_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head_pop    (head_pop),
    .head_op     (head_op),
    .head_xs     (head_xs),
    .head_xe     (head_xe),
    .head_row    (head_row),
    .head_len    (head_len),
    .head_start  (head_start),
    .head_end    (head_end),
    .div_req     (div_req),
    .div_den     (div_den),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .blue_out    (blue_out),
    .green_out   (green_out),
    .red_out     (red_out),
    .alpha_out   (alpha_out),
    .alpha_write (alpha_write),
    .last_pixel  (last_pixel)
  );

endmodule

// ===== hdl/gsd_div.sv =====
// gsd_div: shared serial divider, one quotient bit a cycle, signed result
// truncated toward zero. Depends on gsd_pkg.
module gsd_div import gsd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  input  logic [COORD_BITS:0]   den,
  output div_rsp_t              rsp
);

  logic [DIV_CNT_W-1:0]  cnt;
  logic                  done;
  logic [COLOR_BITS-1:0] num_sh;
  logic [COORD_BITS-1:0] rem;
  logic [COLOR_BITS-1:0] q;
  logic [COORD_BITS-1:0] den_mag;
  logic                  neg;
  logic                  zero;

  logic [COLOR_BITS-1:0] num_mag;
  logic [COORD_BITS-1:0] den_mag_in;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  fits;
  logic [DELTA_BITS-1:0] q_ext;

  assign num_mag    = req.num[DELTA_BITS-1] ? COLOR_BITS'(-req.num) : req.num[COLOR_BITS-1:0];
  assign den_mag_in = den[COORD_BITS] ? COORD_BITS'(-den) : den[COORD_BITS-1:0];
  assign trial      = {rem, num_sh[COLOR_BITS-1]};
  assign fits       = (trial >= {1'b0, den_mag});
  assign diff       = trial - {1'b0, den_mag};
  assign q_ext      = {1'b0, q};

  assign rsp.done = done;
  assign rsp.quo  = zero ? '0 : (neg ? -q_ext : q_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= DIV_CNT_W'(COLOR_BITS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh  <= num_mag;
      rem     <= '0;
      q       <= '0;
      den_mag <= den_mag_in;
      neg     <= req.num[DELTA_BITS-1] ^ den[COORD_BITS];
      zero    <= (den == '0);
    end else if (cnt != '0) begin
      num_sh <= num_sh << 1;
      rem    <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      q      <= {q[COLOR_BITS-2:0], fits};
    end
  end

endmodule

// ===== hdl/gsd_front.sv =====
// gsd_front: input side, takes items, works out the span length and keeps
// them in a short queue for the back end. Depends on gsd_pkg.
module gsd_front import gsd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] row,
  input  logic [COLOR_BITS-1:0] in_start [NUM_CH],
  input  logic [COLOR_BITS-1:0] in_end [NUM_CH],
  output logic                  head_valid,
  input  logic                  head_pop,
  output logic                  head_op,
  output logic [COORD_BITS-1:0] head_xs,
  output logic [COORD_BITS-1:0] head_xe,
  output logic [COORD_BITS-1:0] head_row,
  output logic [COORD_BITS:0]   head_len,
  output logic [COLOR_BITS-1:0] head_start [NUM_CH],
  output logic [COLOR_BITS-1:0] head_end [NUM_CH]
);

  logic                  q_op    [QUEUE_DEPTH];
  logic [COORD_BITS-1:0] q_xs    [QUEUE_DEPTH];
  logic [COORD_BITS-1:0] q_xe    [QUEUE_DEPTH];
  logic [COORD_BITS-1:0] q_row   [QUEUE_DEPTH];
  logic [COORD_BITS:0]   q_len   [QUEUE_DEPTH];
  logic [COLOR_BITS-1:0] q_start [QUEUE_DEPTH][NUM_CH];
  logic [COLOR_BITS-1:0] q_end   [QUEUE_DEPTH][NUM_CH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_stall   = (count == CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign pop        = head_pop && head_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // span length is signed, reversed spans come out negative
  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]    <= opcode;
      q_xs[wr_ptr]    <= x_start;
      q_xe[wr_ptr]    <= x_end;
      q_row[wr_ptr]   <= row;
      q_len[wr_ptr]   <= {1'b0, x_end} - {1'b0, x_start};
      q_start[wr_ptr] <= in_start;
      q_end[wr_ptr]   <= in_end;
    end
  end

  assign head_op    = q_op[rd_ptr];
  assign head_xs    = q_xs[rd_ptr];
  assign head_xe    = q_xe[rd_ptr];
  assign head_row   = q_row[rd_ptr];
  assign head_len   = q_len[rd_ptr];
  assign head_start = q_start[rd_ptr];
  assign head_end   = q_end[rd_ptr];

endmodule

// ===== hdl/gsd_back.sv =====
// gsd_back: span state, delta setup through the divider, per-pixel stepping,
// dither and the output register. Depends on gsd_pkg.
module gsd_back import gsd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  head_valid,
  output logic                  head_pop,
  input  logic                  head_op,
  input  logic [COORD_BITS-1:0] head_xs,
  input  logic [COORD_BITS-1:0] head_xe,
  input  logic [COORD_BITS-1:0] head_row,
  input  logic [COORD_BITS:0]   head_len,
  input  logic [COLOR_BITS-1:0] head_start [NUM_CH],
  input  logic [COLOR_BITS-1:0] head_end [NUM_CH],
  output div_req_t              div_req,
  output logic [COORD_BITS:0]   div_den,
  input  div_rsp_t              div_rsp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [7:0]            blue_out,
  output logic [7:0]            green_out,
  output logic [7:0]            red_out,
  output logic [7:0]            alpha_out,
  output logic                  alpha_write,
  output logic                  last_pixel
);

  back_state_t state;
  back_state_t state_next;
  logic [1:0]  ch;
  logic [1:0]  ch_next;

  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] span_y;
  logic [COLOR_BITS-1:0] color_acc   [NUM_CH];
  logic [DELTA_BITS-1:0] color_delta [NUM_CH];

  logic       active;
  logic       out_free;
  logic       emit;
  logic       load_done;
  logic [7:0] t1;
  logic [7:0] t2;
  logic [7:0] r_byte;
  logic [7:0] g_byte;
  logic [7:0] b_byte;
  logic [7:0] a_byte;

  assign active   = (cur_x < end_x);
  assign out_free = !out_valid || !out_stall;

  assign div_den = head_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next    = state;
    ch_next       = ch;
    head_pop      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {1'b0, head_end[ch]} - {1'b0, head_start[ch]};
    emit          = 1'b0;
    load_done     = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (head_valid) begin
          if (head_op == OP_LOAD) begin
            state_next = ST_DIV_START;
            ch_next    = CH_RED;
          end else if (!active) begin
            head_pop = 1'b1;
          end else if (out_free) begin
            emit     = 1'b1;
            head_pop = 1'b1;
          end
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (ch == CH_ALPHA) begin
            head_pop   = 1'b1;
            load_done  = 1'b1;
            state_next = ST_RUN;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = ST_DIV_START;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // span state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x  <= '0;
      end_x  <= '0;
      span_y <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        color_acc[i]   <= '0;
        color_delta[i] <= '0;
      end
    end else begin
      if (state == ST_DIV_WAIT && div_rsp.done) begin
        color_delta[ch] <= div_rsp.quo;
      end
      if (load_done) begin
        cur_x     <= head_xs;
        end_x     <= head_xe;
        span_y    <= head_row;
        color_acc <= head_start;
      end else if (emit) begin
        cur_x <= cur_x + 1'b1;
        for (int i = 0; i < NUM_CH - 1; i++) begin
          color_acc[i] <= color_acc[i] + color_delta[i][COLOR_BITS-1:0];
        end
        // alpha holds still while dithering
        if (!cfg.dither_enable) begin
          color_acc[CH_ALPHA] <= color_acc[CH_ALPHA] + color_delta[CH_ALPHA][COLOR_BITS-1:0];
        end
      end
    end
  end

  assign t1 = bayer_th({span_y[2:0], cur_x[2:0]});
  assign t2 = bayer_th({3'(span_y[2:0] + 3'd3), 3'(cur_x[2:0] + 3'd2)});

  assign r_byte = color_acc[CH_RED][COLOR_BITS-1:8];
  assign g_byte = color_acc[CH_GREEN][COLOR_BITS-1:8];
  assign b_byte = color_acc[CH_BLUE][COLOR_BITS-1:8];
  assign a_byte = color_acc[CH_ALPHA][COLOR_BITS-1:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x    <= cur_x;
      pixel_y    <= span_y;
      last_pixel <= (({1'b0, cur_x} + 1'b1) == {1'b0, end_x});
      if (cfg.dither_enable) begin
        blue_out    <= dither_level(t1, t2, b_byte, cfg.dither_low);
        green_out   <= dither_level(t1, t2, g_byte, cfg.dither_low);
        red_out     <= dither_level(t1, t2, r_byte, cfg.dither_low);
        alpha_out   <= '0;
        alpha_write <= 1'b0;
      end else begin
        blue_out    <= b_byte;
        green_out   <= g_byte;
        red_out     <= r_byte;
        alpha_out   <= a_byte;
        alpha_write <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/gsd_checker.sv =====
// gsd_checker: port-level assertions for gouraud_span_dither_engine, bound to
// the top level below. Depends on gsd_pkg.
module gsd_checker import gsd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_IDX_BITS-1:0] cfg_index,
  input logic                    cfg_data,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    opcode,
  input logic [COORD_BITS-1:0]   x_start,
  input logic [COORD_BITS-1:0]   x_end,
  input logic [COORD_BITS-1:0]   row,
  input logic [COLOR_BITS-1:0]   red_start,
  input logic [COLOR_BITS-1:0]   green_start,
  input logic [COLOR_BITS-1:0]   blue_start,
  input logic [COLOR_BITS-1:0]   alpha_start,
  input logic [COLOR_BITS-1:0]   red_end,
  input logic [COLOR_BITS-1:0]   green_end,
  input logic [COLOR_BITS-1:0]   blue_end,
  input logic [COLOR_BITS-1:0]   alpha_end,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [COORD_BITS-1:0]   pixel_x,
  input logic [COORD_BITS-1:0]   pixel_y,
  input logic [7:0]              blue_out,
  input logic [7:0]              green_out,
  input logic [7:0]              red_out,
  input logic [7:0]              alpha_out,
  input logic                    alpha_write,
  input logic                    last_pixel
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  // and its payload does not move
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y) && $stable(red_out)
      && $stable(green_out) && $stable(blue_out) && $stable(last_pixel))
    else $error("stalled output payload changed");

  // dithered pixels carry no alpha
  a_alpha_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !alpha_write |-> alpha_out == LEVEL_LOW)
    else $error("alpha not zero on dithered pixel");

  // dithered colour bytes only take the three levels
  a_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid && !alpha_write |->
      (red_out == LEVEL_LOW || red_out == LEVEL_MID || red_out == LEVEL_HIGH) &&
      (green_out == LEVEL_LOW || green_out == LEVEL_MID || green_out == LEVEL_HIGH) &&
      (blue_out == LEVEL_LOW || blue_out == LEVEL_MID || blue_out == LEVEL_HIGH))
    else $error("dithered byte off the level set");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind gouraud_span_dither_engine gsd_checker #(.COORD_BITS(COORD_BITS)) u_gsd_checker (.*);
